### design/look_at_view_matrix_unit_macros.svh
// Assertion macros used by the checker file of the look-at matrix unit.
`ifndef LOOK_AT_VIEW_MATRIX_UNIT_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_UNIT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define LMV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define LMV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### design/lmv_pkg.sv
// Types and constants of the look-at view matrix unit.
package lmv_pkg;

    localparam int NORM_BITS = 31;
    localparam int AXIS_FRAC = 30;

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;

    typedef logic [2:0][31:0] t_v32;
    typedef logic [2:0][63:0] t_v64;

    // Data that rides along the normalizer pipelines.
    typedef struct packed {
        t_v32 eye;
        t_v32 up;
        t_v32 fwd;
        t_v32 rgt;
        logic degen;
    } t_side;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_hint_x;
        logic signed [31:0] up_hint_y;
        logic signed [31:0] up_hint_z;
    } t_in;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic signed [39:0] translation;
        logic               last_row;
        logic               degenerate;
    } t_out;

endpackage

### design/lmv_norm.sv
// Pipelined vector normalizer: scale, sum of squares, square root, three dividers.
module lmv_norm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  lmv_pkg::t_v64 i_vec,
    input  lmv_pkg::t_side i_side,
    output logic          o_valid,
    output lmv_pkg::t_v32 o_axis,
    output logic          o_zero,
    output lmv_pkg::t_side o_side
);
    import lmv_pkg::*;

    typedef struct packed {
        t_side            side;
        logic [2:0]       sgn;
        logic             zero;
        logic [2:0][31:0] ms;
    } t_nctx;

    // Stage 1: magnitudes and their OR, whose bit length equals that of the largest.
    logic [2:0]       n_sgn;
    logic [2:0][62:0] n_mag;
    logic [63:0]      w_abs;

    always_comb begin
        w_abs = '0;
        for (int c = 0; c < 3; c++) begin
            n_sgn[c] = i_vec[c][63];
            w_abs    = n_sgn[c] ? (64'd0 - i_vec[c]) : i_vec[c];
            n_mag[c] = w_abs[62:0];
        end
    end

    logic             r_s1_v;
    t_side            r_s1_side;
    logic [2:0]       r_s1_sgn;
    logic [2:0][62:0] r_s1_m;
    logic [62:0]      r_s1_or;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_adv) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_side <= i_side;
            r_s1_sgn  <= n_sgn;
            r_s1_m    <= n_mag;
            r_s1_or   <= n_mag[0] | n_mag[1] | n_mag[2];
        end
    end

    // Stage 2: bit length of the largest magnitude.
    logic [5:0] n_blen;

    always_comb begin
        n_blen = '0;
        for (int i = 0; i < 63; i++) begin
            if (r_s1_or[i]) begin
                n_blen = 6'(i + 1);
            end
        end
    end

    logic             r_s2_v;
    t_side            r_s2_side;
    logic [2:0]       r_s2_sgn;
    logic [2:0][62:0] r_s2_m;
    logic [5:0]       r_s2_b;
    logic             r_s2_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (i_adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_side <= r_s1_side;
            r_s2_sgn  <= r_s1_sgn;
            r_s2_m    <= r_s1_m;
            r_s2_b    <= n_blen;
            r_s2_zero <= (r_s1_or == '0);
        end
    end

    // Stage 3: scale so the largest magnitude has NORM_BITS bits, or one more when rounding carries.
    logic [2:0][31:0] n_ms;
    logic [5:0]       w_sh;
    logic [63:0]      w_t;

    always_comb begin
        w_sh = '0;
        w_t  = '0;
        for (int c = 0; c < 3; c++) begin
            if (r_s2_b > 6'(NORM_BITS)) begin
                w_sh = r_s2_b - 6'(NORM_BITS);
                w_t  = ({1'b0, r_s2_m[c]} + (64'd1 << (w_sh - 6'd1))) >> w_sh;
            end else begin
                w_sh = 6'(NORM_BITS) - r_s2_b;
                w_t  = {1'b0, r_s2_m[c]} << w_sh;
            end
            n_ms[c] = w_t[31:0];
        end
    end

    logic  r_s3_v;
    t_nctx r_s3_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (i_adv) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s3_ctx.side <= r_s2_side;
            r_s3_ctx.sgn  <= r_s2_sgn;
            r_s3_ctx.zero <= r_s2_zero;
            r_s3_ctx.ms   <= n_ms;
        end
    end

    // Stage 4: squares.
    logic             r_s4_v;
    t_nctx            r_s4_ctx;
    logic [2:0][63:0] r_s4_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (i_adv) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s4_ctx <= r_s3_ctx;
            for (int c = 0; c < 3; c++) begin
                r_s4_sq[c] <= 64'(r_s3_ctx.ms[c]) * 64'(r_s3_ctx.ms[c]);
            end
        end
    end

    // Square root, one result bit per stage.
    logic        r_q_v    [0:32];
    t_nctx       r_q_ctx  [0:32];
    logic [63:0] r_q_n    [0:32];
    logic [34:0] r_q_rem  [0:32];
    logic [31:0] r_q_root [0:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_q_v[0] <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_q_ctx[0]  <= r_s4_ctx;
            r_q_n[0]    <= r_s4_sq[0] + r_s4_sq[1] + r_s4_sq[2];
            r_q_rem[0]  <= '0;
            r_q_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < 32; k++) begin : g_sqrt
        logic [34:0] n_rem_sh;
        logic [34:0] n_trial;
        logic        n_ge;

        always_comb begin
            n_rem_sh = {r_q_rem[k][32:0], r_q_n[k][63:62]};
            n_trial  = {1'b0, r_q_root[k], 2'b01};
            n_ge     = (n_rem_sh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_v[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_q_v[k+1] <= r_q_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_q_ctx[k+1]  <= r_q_ctx[k];
                r_q_n[k+1]    <= r_q_n[k] << 2;
                r_q_rem[k+1]  <= n_ge ? (n_rem_sh - n_trial) : n_rem_sh;
                r_q_root[k+1] <= {r_q_root[k][30:0], n_ge};
            end
        end
    end

    // Divider setup: dividend is the scaled component shifted up, plus half the length.
    logic [2:0][61:0] n_num;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_num[c] = {r_q_ctx[32].ms[c], 30'd0} + {31'd0, r_q_root[32][31:1]};
        end
    end

    logic             r_d_v   [0:32];
    t_nctx            r_d_ctx [0:32];
    logic [31:0]      r_d_len [0:32];
    logic [2:0][32:0] r_d_rem [0:32];
    logic [2:0][31:0] r_d_lo  [0:32];
    logic [2:0][31:0] r_d_q   [0:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_d_v[0] <= r_q_v[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d_ctx[0] <= r_q_ctx[32];
            r_d_len[0] <= r_q_root[32];
            for (int c = 0; c < 3; c++) begin
                r_d_rem[0][c] <= {3'd0, n_num[c][61:32]};
                r_d_lo[0][c]  <= n_num[c][31:0];
                r_d_q[0][c]   <= '0;
            end
        end
    end

    // Restoring division, one quotient bit per stage for all three components.
    for (genvar k = 0; k < 32; k++) begin : g_div
        logic [2:0][32:0] n_rem_sh;
        logic [2:0]       n_ge;

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                n_rem_sh[c] = {r_d_rem[k][c][31:0], r_d_lo[k][c][31]};
                n_ge[c]     = (n_rem_sh[c] >= {1'b0, r_d_len[k]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_v[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_d_v[k+1] <= r_d_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_d_ctx[k+1] <= r_d_ctx[k];
                r_d_len[k+1] <= r_d_len[k];
                for (int c = 0; c < 3; c++) begin
                    r_d_rem[k+1][c] <= n_ge[c] ? (n_rem_sh[c] - {1'b0, r_d_len[k]})
                                               : n_rem_sh[c];
                    r_d_lo[k+1][c]  <= r_d_lo[k][c] << 1;
                    r_d_q[k+1][c]   <= {r_d_q[k][c][30:0], n_ge[c]};
                end
            end
        end
    end

    // Clamp to one, apply the sign, and force a zero vector to the zero axis.
    localparam logic [31:0] AxisOne = 32'd1 << AXIS_FRAC;

    t_v32        n_axis;
    logic [31:0] w_qc;

    always_comb begin
        w_qc = '0;
        for (int c = 0; c < 3; c++) begin
            w_qc = (r_d_q[32][c] > AxisOne) ? AxisOne : r_d_q[32][c];
            if (r_d_ctx[32].zero) begin
                n_axis[c] = '0;
            end else if (r_d_ctx[32].sgn[c]) begin
                n_axis[c] = 32'd0 - w_qc;
            end else begin
                n_axis[c] = w_qc;
            end
        end
    end

    logic r_f_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (i_adv) begin
            r_f_v <= r_d_v[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_axis <= n_axis;
            o_zero <= r_d_ctx[32].zero;
            o_side <= r_d_ctx[32].side;
        end
    end

    assign o_valid = r_f_v;

endmodule

### design/look_at_view_matrix_unit.sv
// Look-at view matrix unit: three normalizers, two cross products and the translations.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-----------------------
//  input   | i_in_valid  | o_in_stall   | i_in  (lmv_pkg::t_in)
//  result  | o_out_valid | i_out_stall  | o_out (lmv_pkg::t_out)
//
// Each item yields three result rows (right, up, forward), which follow one per cycle
// while i_out_stall is low. Items enter while the pipeline advances, several in flight;
// once it backs up, the three result rows of each item set the input pace.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
// One advance signal moves the whole pipeline; it drops only while a finished
// item cannot enter the output register, and then the input is stalled too.
module look_at_view_matrix_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lmv_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lmv_pkg::t_out o_out
);
    import lmv_pkg::*;

    logic adv;

    // Input: forward direction is eye minus target at full width.
    t_v32  w_eye;
    t_v32  w_tgt;
    t_v32  w_up;
    t_v64  w_diff;
    t_side w_side_in;

    always_comb begin
        w_eye = {i_in.eye_z, i_in.eye_y, i_in.eye_x};
        w_tgt = {i_in.target_z, i_in.target_y, i_in.target_x};
        w_up  = {i_in.up_hint_z, i_in.up_hint_y, i_in.up_hint_x};
        for (int c = 0; c < 3; c++) begin
            w_diff[c] = 64'($signed(w_eye[c])) - 64'($signed(w_tgt[c]));
        end
        w_side_in.eye   = w_eye;
        w_side_in.up    = w_up;
        w_side_in.fwd   = '0;
        w_side_in.rgt   = '0;
        w_side_in.degen = 1'b0;
    end

    logic  a_v;
    t_v32  a_axis;
    logic  a_zero;
    t_side a_side;

    lmv_norm u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_in_valid),
        .i_vec   (w_diff),
        .i_side  (w_side_in),
        .o_valid (a_v),
        .o_axis  (a_axis),
        .o_zero  (a_zero),
        .o_side  (a_side)
    );

    // Right = up hint x forward: products, then differences.
    logic                    r_c1_v;
    t_side                   r_c1_side;
    t_side                   n_c1_side;
    logic [2:0][1:0][63:0]   r_c1_p;

    always_comb begin
        n_c1_side       = a_side;
        n_c1_side.fwd   = a_axis;
        n_c1_side.degen = a_side.degen | a_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
        end else if (adv) begin
            r_c1_v <= a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c1_side    <= n_c1_side;
            r_c1_p[0][0] <= 64'($signed(a_side.up[1]) * $signed(a_axis[2]));
            r_c1_p[0][1] <= 64'($signed(a_side.up[2]) * $signed(a_axis[1]));
            r_c1_p[1][0] <= 64'($signed(a_side.up[2]) * $signed(a_axis[0]));
            r_c1_p[1][1] <= 64'($signed(a_side.up[0]) * $signed(a_axis[2]));
            r_c1_p[2][0] <= 64'($signed(a_side.up[0]) * $signed(a_axis[1]));
            r_c1_p[2][1] <= 64'($signed(a_side.up[1]) * $signed(a_axis[0]));
        end
    end

    logic  r_c2_v;
    t_side r_c2_side;
    t_v64  r_c2_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_v <= 1'b0;
        end else if (adv) begin
            r_c2_v <= r_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c2_side <= r_c1_side;
            for (int c = 0; c < 3; c++) begin
                r_c2_vec[c] <= r_c1_p[c][0] - r_c1_p[c][1];
            end
        end
    end

    logic  b_v;
    t_v32  b_axis;
    logic  b_zero;
    t_side b_side;

    lmv_norm u_norm_rgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_c2_v),
        .i_vec   (r_c2_vec),
        .i_side  (r_c2_side),
        .o_valid (b_v),
        .o_axis  (b_axis),
        .o_zero  (b_zero),
        .o_side  (b_side)
    );

    // True up = forward x right.
    logic                  r_c3_v;
    t_side                 r_c3_side;
    t_side                 n_c3_side;
    logic [2:0][1:0][63:0] r_c3_p;

    always_comb begin
        n_c3_side       = b_side;
        n_c3_side.rgt   = b_axis;
        n_c3_side.degen = b_side.degen | b_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3_v <= 1'b0;
        end else if (adv) begin
            r_c3_v <= b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c3_side    <= n_c3_side;
            r_c3_p[0][0] <= 64'($signed(b_side.fwd[1]) * $signed(b_axis[2]));
            r_c3_p[0][1] <= 64'($signed(b_side.fwd[2]) * $signed(b_axis[1]));
            r_c3_p[1][0] <= 64'($signed(b_side.fwd[2]) * $signed(b_axis[0]));
            r_c3_p[1][1] <= 64'($signed(b_side.fwd[0]) * $signed(b_axis[2]));
            r_c3_p[2][0] <= 64'($signed(b_side.fwd[0]) * $signed(b_axis[1]));
            r_c3_p[2][1] <= 64'($signed(b_side.fwd[1]) * $signed(b_axis[0]));
        end
    end

    logic  r_c4_v;
    t_side r_c4_side;
    t_v64  r_c4_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c4_v <= 1'b0;
        end else if (adv) begin
            r_c4_v <= r_c3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c4_side <= r_c3_side;
            for (int c = 0; c < 3; c++) begin
                r_c4_vec[c] <= r_c3_p[c][0] - r_c3_p[c][1];
            end
        end
    end

    logic  v_v;
    t_v32  v_axis;
    logic  v_zero;
    t_side v_side;

    lmv_norm u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_c4_v),
        .i_vec   (r_c4_vec),
        .i_side  (r_c4_side),
        .o_valid (v_v),
        .o_axis  (v_axis),
        .o_zero  (v_zero),
        .o_side  (v_side)
    );

    // Translations: axis times eye per row, sum, then negate and round.
    t_v32 [2:0] w_rows;

    assign w_rows[ROW_RIGHT] = v_side.rgt;
    assign w_rows[ROW_UP]    = v_axis;
    assign w_rows[ROW_FWD]   = v_side.fwd;

    logic                  r_t1_v;
    t_v32 [2:0]            r_t1_ax;
    logic                  r_t1_dg;
    logic [2:0][2:0][63:0] r_t1_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
        end else if (adv) begin
            r_t1_v <= v_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t1_ax <= w_rows;
            r_t1_dg <= v_side.degen | v_zero;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_t1_p[r][c] <= 64'($signed(w_rows[r][c]) * $signed(v_side.eye[c]));
                end
            end
        end
    end

    logic             r_t2_v;
    t_v32 [2:0]       r_t2_ax;
    logic             r_t2_dg;
    logic [2:0][63:0] r_t2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2_v <= 1'b0;
        end else if (adv) begin
            r_t2_v <= r_t1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t2_ax <= r_t1_ax;
            r_t2_dg <= r_t1_dg;
            for (int r = 0; r < 3; r++) begin
                r_t2_d[r] <= r_t1_p[r][0] + r_t1_p[r][1] + r_t1_p[r][2];
            end
        end
    end

    // Round the magnitude half up, ties away from zero on the signed value.
    logic [2:0][39:0] n_tr;
    logic [63:0]      w_neg;
    logic [63:0]      w_mag;
    logic [63:0]      w_rnd;

    always_comb begin
        w_neg = '0;
        w_mag = '0;
        w_rnd = '0;
        for (int r = 0; r < 3; r++) begin
            w_neg   = 64'd0 - r_t2_d[r];
            w_mag   = w_neg[63] ? (64'd0 - w_neg) : w_neg;
            w_rnd   = (w_mag + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
            n_tr[r] = w_neg[63] ? (40'd0 - w_rnd[39:0]) : w_rnd[39:0];
        end
    end

    logic             r_t3_v;
    t_v32 [2:0]       r_t3_ax;
    logic             r_t3_dg;
    logic [2:0][39:0] r_t3_tr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t3_v <= 1'b0;
        end else if (adv) begin
            r_t3_v <= r_t2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t3_ax <= r_t2_ax;
            r_t3_dg <= r_t2_dg;
            r_t3_tr <= n_tr;
        end
    end

    // Output register holds one whole matrix and sends its rows in order.
    logic             r_ov;
    logic [1:0]       r_row;
    t_v32 [2:0]       r_o_ax;
    logic [2:0][39:0] r_o_tr;
    logic             r_o_dg;
    logic             w_load_ok;
    logic             w_load;

    assign w_load_ok  = !r_ov || ((r_row == ROW_FWD) && !i_out_stall);
    assign w_load     = r_t3_v && w_load_ok;
    assign adv        = !r_t3_v || w_load_ok;
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_row <= ROW_RIGHT;
        end else if (w_load) begin
            r_ov  <= 1'b1;
            r_row <= ROW_RIGHT;
        end else if (r_ov && !i_out_stall) begin
            if (r_row == ROW_FWD) begin
                r_ov <= 1'b0;
            end else begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_ax <= r_t3_ax;
            r_o_tr <= r_t3_tr;
            r_o_dg <= r_t3_dg;
        end
    end

    t_v32        w_ax;
    logic [39:0] w_tr;

    always_comb begin
        unique case (r_row)
            ROW_RIGHT: begin
                w_ax = r_o_ax[ROW_RIGHT];
                w_tr = r_o_tr[ROW_RIGHT];
            end
            ROW_UP: begin
                w_ax = r_o_ax[ROW_UP];
                w_tr = r_o_tr[ROW_UP];
            end
            ROW_FWD: begin
                w_ax = r_o_ax[ROW_FWD];
                w_tr = r_o_tr[ROW_FWD];
            end
            default: begin
                w_ax = '0;
                w_tr = '0;
            end
        endcase
    end

    assign o_out_valid       = r_ov;
    assign o_out.row_index   = r_row;
    assign o_out.axis_x      = w_ax[0];
    assign o_out.axis_y      = w_ax[1];
    assign o_out.axis_z      = w_ax[2];
    assign o_out.translation = w_tr;
    assign o_out.last_row    = (r_row == ROW_FWD);
    assign o_out.degenerate  = r_o_dg;

endmodule

### design/lmv_checker.sv
// Port checker for the look-at view matrix unit, bound to the top level.
`include "look_at_view_matrix_unit_macros.svh"

module lmv_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_stall,
    input lmv_pkg::t_out i_out
);
    import lmv_pkg::*;

    logic w_xfer;

    assign w_xfer = i_out_valid && !i_out_stall;

    `LMV_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out), "stalled result changed")
    `LMV_ASSERT_NEXT(a_row_up, w_xfer && i_out.row_index == ROW_RIGHT, i_out_valid && i_out.row_index == ROW_UP && i_out.degenerate == $past(i_out.degenerate), "up row does not follow right row")
    `LMV_ASSERT_NEXT(a_row_fwd, w_xfer && i_out.row_index == ROW_UP, i_out_valid && i_out.row_index == ROW_FWD && i_out.degenerate == $past(i_out.degenerate), "forward row does not follow up row")
    `LMV_ASSERT_NOW(a_last_row, i_out_valid, i_out.last_row == (i_out.row_index == ROW_FWD), "last row flag wrong")

endmodule

bind look_at_view_matrix_unit lmv_checker u_lmv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

### bench/lmv_checker.sv
// Scoreboard for the look-at view matrix unit: predicts the three rows of each input transfer.
`timescale 1ns / 1ps

module lmv_scoreboard (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  lmv_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  lmv_pkg::t_out i_out,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_rows_checked
);
    import lmv_pkg::*;

    t_out row_queue[$];

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint unsigned sqrt_floor(input longint unsigned n);
        longint unsigned r = 0;
        longint unsigned bitv = 64'h1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    // Returns 1 when the vector is zero; the axis is then zero too.
    function automatic bit unit_axis(input longint v[3], output longint a[3]);
        longint unsigned m[3];
        longint unsigned mx = 0, sum = 0, len, q;
        int b = 0;
        int s;
        for (int i = 0; i < 3; i++) begin
            m[i] = magnitude(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            a = '{0, 0, 0};
            return 1;
        end
        while (b < 64 && (mx >> b) != 0) b++;
        for (int i = 0; i < 3; i++) begin
            if (b > NORM_BITS) begin
                s = b - NORM_BITS;
                m[i] = (m[i] + (64'h1 << (s - 1))) >> s;
            end else if (b < NORM_BITS) begin
                m[i] = m[i] << (NORM_BITS - b);
            end
            sum += m[i] * m[i];
        end
        len = sqrt_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << AXIS_FRAC) + (len >> 1)) / len;
            if (q > (64'h1 << AXIS_FRAC)) q = 64'h1 << AXIS_FRAC;
            a[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 0;
    endfunction

    function automatic void cross_prod(input longint p[3], input longint q[3],
                                       output longint r[3]);
        r[0] = p[1] * q[2] - p[2] * q[1];
        r[1] = p[2] * q[0] - p[0] * q[2];
        r[2] = p[0] * q[1] - p[1] * q[0];
    endfunction

    function automatic logic [39:0] shifted_translation(input longint ax[3],
                                                        input longint e[3]);
        longint d, t;
        longint unsigned m;
        d = ax[0] * e[0] + ax[1] * e[1] + ax[2] * e[2];
        t = -d;
        m = (magnitude(t) + (64'h1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
        return (t < 0) ? 40'(-longint'(m)) : 40'(m);
    endfunction

    task automatic predict_rows(input t_in x);
        longint eye[3], up[3], diff[3], tmp[3];
        longint axes[3][3];
        bit degen;
        t_out r;
        eye = '{x.eye_x, x.eye_y, x.eye_z};
        up = '{x.up_hint_x, x.up_hint_y, x.up_hint_z};
        diff = '{longint'(x.eye_x) - x.target_x, longint'(x.eye_y) - x.target_y,
                 longint'(x.eye_z) - x.target_z};
        degen = unit_axis(diff, axes[2]);
        cross_prod(up, axes[2], tmp);
        degen |= unit_axis(tmp, axes[0]);
        cross_prod(axes[2], axes[0], tmp);
        degen |= unit_axis(tmp, axes[1]);
        for (int k = 0; k < 3; k++) begin
            r.row_index   = 2'(k);
            r.axis_x      = 32'(axes[k][0]);
            r.axis_y      = 32'(axes[k][1]);
            r.axis_z      = 32'(axes[k][2]);
            r.translation = shifted_translation(axes[k], eye);
            r.last_row    = (2'(k) == ROW_FWD);
            r.degenerate  = degen;
            row_queue.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        o_fail_count++;
        $display("%0t: row %0d %s mismatch: got %h expected %h",
                 $realtime, o_rows_checked, what, got, want);
    endtask

    initial begin
        o_fail_count = 0;
        o_rows_checked = 0;
    end

    assign o_pending = row_queue.size();

    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) predict_rows(i_in);
            if (i_out_valid && !i_out_stall) begin
                if (row_queue.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result transfer", $realtime);
                end else begin
                    w = row_queue.pop_front();
                    if (i_out.row_index !== w.row_index)
                        report_mismatch("row_index", i_out.row_index, w.row_index);
                    if (i_out.axis_x !== w.axis_x)
                        report_mismatch("axis_x", i_out.axis_x, w.axis_x);
                    if (i_out.axis_y !== w.axis_y)
                        report_mismatch("axis_y", i_out.axis_y, w.axis_y);
                    if (i_out.axis_z !== w.axis_z)
                        report_mismatch("axis_z", i_out.axis_z, w.axis_z);
                    if (i_out.translation !== w.translation)
                        report_mismatch("translation", i_out.translation, w.translation);
                    if (i_out.last_row !== w.last_row)
                        report_mismatch("last_row", i_out.last_row, w.last_row);
                    if (i_out.degenerate !== w.degenerate)
                        report_mismatch("degenerate", i_out.degenerate, w.degenerate);
                end
                o_rows_checked++;
            end
        end
    end

endmodule

### bench/testbench.sv
// Top of the look-at view matrix testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import lmv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_stall;
    t_in   i_in;
    logic  o_out_valid;
    logic  i_out_stall;
    t_out  o_out;

    int fail_count, pending, rows_checked;
    int send_idle_pct, recv_stall_pct;
    int hold_cycles;
    int items_sent;
    longint cycles;

    look_at_view_matrix_unit dut (.*);

    lmv_scoreboard u_scoreboard (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_in,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out(o_out),
        .o_fail_count(fail_count), .o_pending(pending), .o_rows_checked(rows_checked)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off while hold_cycles counts down.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic send_item(input t_in x);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in <= t_in'({$urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom});
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= x;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Mix of full-range, scaled and small values so every magnitude range shows up.
    function automatic logic [31:0] any_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom >>> $urandom_range(31);
            2: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
            default: return 32'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    function automatic t_in random_item();
        t_in x;
        x = '{any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
              any_coord(), any_coord(), any_coord(), any_coord()};
        case ($urandom_range(19))
            0: {x.target_x, x.target_y, x.target_z} = {x.eye_x, x.eye_y, x.eye_z};
            1: begin
                // Up hint parallel to the view direction.
                x.eye_x = $signed($urandom_range(65535)) - 32768;
                x.eye_y = $signed($urandom_range(65535)) - 32768;
                x.eye_z = $signed($urandom_range(65535)) - 32768;
                x.up_hint_x = x.eye_x - x.target_x;
                x.up_hint_y = x.eye_y - x.target_y;
                x.up_hint_z = x.eye_z - x.target_z;
            end
            2: x = t_in'({$urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom});
            default: ;
        endcase
        return x;
    endfunction

    task automatic run_directed();
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] MINV = 32'h8000_0000;
        localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
        send_item('{0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0});
        send_item('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_item('{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0});
        send_item('{0, 0, ONE, 0, 0, 0, 0, 0, ONE});
        send_item('{0, 0, ONE, 0, 0, 0, 0, 0, 0});
        send_item('{MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MINV, MAXV});
        send_item('{MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MINV, MINV});
        send_item('{MAXV, MINV, 0, MINV, MAXV, 0, 0, 0, MAXV});
        send_item('{1, 0, 0, 0, 0, 0, 0, 1, 0});
        send_item('{-1, -1, -1, 0, 0, 0, 1, 0, 0});
        send_item('{3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, ONE});
        send_item('{-ONE, ONE, -ONE, ONE, -ONE, ONE, 0, ONE, 0});
        send_item('{MAXV, 0, 0, MINV, 0, 0, 0, MAXV, 0});
        send_item('{0, MAXV, 0, 0, MINV, 0, MAXV, 0, 0});
        send_item('{12345, -6789, 1 << 20, -1 << 18, 99, 7, 1, 1, 1});
        send_item('{32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F,
                    32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC, 32'h7777_7777,
                    32'h8888_8888});
    endtask

    initial begin
        int idle_set[4];
        int stall_set[4];
        idle_set = '{0, 61, 0, 11};
        stall_set = '{0, 0, 61, 11};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        items_sent = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_set[p];
            recv_stall_pct = stall_set[p];
            // Hold the result side for a long while so the pipeline backs up.
            if (p == 0) hold_cycles = 600;
            repeat (100) send_item(random_item());
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Sent %0d view setups, checked %0d matrix rows across four traffic mixes,",
                 items_sent, rows_checked);
        $display("including zero-length views, parallel up hints and full-range coordinates.");
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/lmv_pkg.sv
design/lmv_norm.sv
design/look_at_view_matrix_unit.sv
design/lmv_checker.sv
bench/lmv_checker.sv
bench/testbench.sv
